// File: hdl/box_filter_downscaler_assert.svh
// ----------------------------------------------------------------------------
// Box filter downscaler assertion macros
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef BOX_FILTER_DOWNSCALER_ASSERT_SVH
`define BOX_FILTER_DOWNSCALER_ASSERT_SVH

// property must hold at every clock edge out of reset
`define BFD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) \
      else $error(msg);

// expression must never be true out of reset
`define BFD_ASSERT_NEVER(label, expr, msg) \
   label: assert property (@(posedge clock) disable iff (reset) !(expr)) \
      else $error(msg);

`endif

// File: hdl/bfd_pkg.sv
// ----------------------------------------------------------------------------
// bfd_pkg
// Shared types and constants of the box filter downscaler.
// ----------------------------------------------------------------------------
`default_nettype none

package bfd_pkg;

   localparam int PIX_W       = 8;
   localparam int CHAN_N      = 4;
   localparam int SIZE_W      = 14;
   localparam int POS_W       = 13;
   localparam int TGT_W_REG_W = 12;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 14;
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [SIZE_W-1:0] SOURCE_LIMIT = 14'd8192;

   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_WIDTH  = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_SOURCE_HEIGHT = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_WIDTH  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] REG_TARGET_HEIGHT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] REG_FOUR_CHANNELS = 3'd4;

   typedef struct packed {
      logic [PIX_W-1:0] in_chan0;
      logic [PIX_W-1:0] in_chan1;
      logic [PIX_W-1:0] in_chan2;
      logic [PIX_W-1:0] in_chan3;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0] out_chan0;
      logic [PIX_W-1:0] out_chan1;
      logic [PIX_W-1:0] out_chan2;
      logic [PIX_W-1:0] out_chan3;
      logic             image_done;
   } rsp_type;

   typedef struct packed {
      logic busy;
      logic restart;
   } ctl_type;

   typedef enum logic [2:0] {
      SU_LOAD,
      SU_SCALE,
      SU_AREA,
      SU_RECIP,
      SU_IDLE
   } setup_state_type;

endpackage

`default_nettype wire

// File: hdl/bfd_setup.sv
// ----------------------------------------------------------------------------
// bfd_setup
// Config registers, scale search, box area and area reciprocal.
// ----------------------------------------------------------------------------
`default_nettype none
`include "box_filter_downscaler_assert.svh"

module bfd_setup #(
   parameter int MAX_TARGET_WIDTH = 2048,
   parameter int MAX_SCALE        = 16
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_valid,
   output      logic                               csr_ready,
   input  wire logic [bfd_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  wire logic [bfd_pkg::CSR_DATA_W-1:0]     csr_data,
   output      bfd_pkg::ctl_type                   ctl,
   output      logic [bfd_pkg::SIZE_W-1:0]         src_w,
   output      logic [bfd_pkg::SIZE_W-1:0]         src_h,
   output      logic [bfd_pkg::SIZE_W-1:0]         cover_w,
   output      logic [bfd_pkg::SIZE_W-1:0]         cover_h,
   output      logic [$clog2(MAX_SCALE+1)-1:0]     scale_w,
   output      logic [$clog2(MAX_SCALE+1)-1:0]     scale_h,
   output      logic [$clog2(MAX_SCALE*MAX_SCALE+1)-1:0] area,
   output      logic [$clog2(((1 << bfd_pkg::PIX_W) - 1) * MAX_SCALE * MAX_SCALE + 1):0]
                                                   recip,
   output      logic                               four_channels
);
   import bfd_pkg::*;

   localparam int SC_W   = $clog2(MAX_SCALE + 1);
   localparam int AREA_W = $clog2(MAX_SCALE * MAX_SCALE + 1);
   localparam int SUM_W  = $clog2(((1 << PIX_W) - 1) * MAX_SCALE * MAX_SCALE + 1);
   localparam int RCP_W  = SUM_W + 1;
   localparam int CNT_W  = $clog2(SUM_W + 1);
   localparam logic [SIZE_W-1:0] MTW_SZ   = SIZE_W'(MAX_TARGET_WIDTH);
   localparam logic [SC_W-1:0]   SCALE_MX = SC_W'(MAX_SCALE);
   localparam logic [CNT_W-1:0]  CNT_TOP  = CNT_W'(SUM_W);

   logic [SIZE_W-1:0]      src_w_ff, src_h_ff, tgt_h_ff;
   logic [TGT_W_REG_W-1:0] tgt_w_ff;
   logic                   four_ff;
   logic                   write_hit;

   setup_state_type state_ff, state_in;

   logic [SIZE_W-1:0] sw_eff, sh_eff, tw_eff, th_eff, tw_raw;
   logic [SIZE_W-1:0] sw_ff, sh_ff, tw_ff, th_ff;
   logic [SIZE_W-1:0] acc_w_ff, acc_h_ff;
   logic [SC_W-1:0]   k_w_ff, k_h_ff;
   logic [SIZE_W:0]   acc_w_next, acc_h_next;
   logic              adv_w, adv_h;
   logic [AREA_W-1:0] area_ff, rem_ff, rem_in;
   logic [AREA_W:0]   trial;
   logic              trial_ge;
   logic [RCP_W-1:0]  q_ff;
   logic [CNT_W-1:0]  cnt_ff;

   assign csr_ready = 1'b1;

   always_comb begin
      case (csr_index)
         REG_SOURCE_WIDTH, REG_SOURCE_HEIGHT, REG_TARGET_WIDTH,
         REG_TARGET_HEIGHT, REG_FOUR_CHANNELS: write_hit = csr_valid;
         default: write_hit = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff <= SIZE_W'(1);
         src_h_ff <= SIZE_W'(1);
         tgt_w_ff <= TGT_W_REG_W'(1);
         tgt_h_ff <= SIZE_W'(1);
         four_ff  <= 1'b1;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            REG_SOURCE_WIDTH:  src_w_ff <= csr_data[SIZE_W-1:0];
            REG_SOURCE_HEIGHT: src_h_ff <= csr_data[SIZE_W-1:0];
            REG_TARGET_WIDTH:  tgt_w_ff <= csr_data[TGT_W_REG_W-1:0];
            REG_TARGET_HEIGHT: tgt_h_ff <= csr_data[SIZE_W-1:0];
            REG_FOUR_CHANNELS: four_ff  <= csr_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (src_w_ff == '0)               sw_eff = SIZE_W'(1);
      else if (src_w_ff > SOURCE_LIMIT) sw_eff = SOURCE_LIMIT;
      else                              sw_eff = src_w_ff;
      if (src_h_ff == '0)               sh_eff = SIZE_W'(1);
      else if (src_h_ff > SOURCE_LIMIT) sh_eff = SOURCE_LIMIT;
      else                              sh_eff = src_h_ff;
      tw_raw = SIZE_W'(tgt_w_ff);
      if (tw_raw == '0)        tw_eff = SIZE_W'(1);
      else if (tw_raw > sw_eff) tw_eff = sw_eff;
      else                     tw_eff = tw_raw;
      if (tw_eff > MTW_SZ)     tw_eff = MTW_SZ;
      if (tgt_h_ff == '0)        th_eff = SIZE_W'(1);
      else if (tgt_h_ff > sh_eff) th_eff = sh_eff;
      else                       th_eff = tgt_h_ff;
   end

   assign acc_w_next = {1'b0, acc_w_ff} + {1'b0, tw_ff};
   assign acc_h_next = {1'b0, acc_h_ff} + {1'b0, th_ff};
   assign adv_w      = (k_w_ff < SCALE_MX) && (acc_w_next <= {1'b0, sw_ff});
   assign adv_h      = (k_h_ff < SCALE_MX) && (acc_h_next <= {1'b0, sh_ff});

   assign trial    = {rem_ff, (cnt_ff == CNT_TOP)};
   assign trial_ge = trial >= {1'b0, area_ff};
   assign rem_in   = trial_ge ? AREA_W'(trial - {1'b0, area_ff}) : AREA_W'(trial);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SU_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         SU_LOAD:  state_in = SU_SCALE;
         SU_SCALE: if (!adv_w && !adv_h) state_in = SU_AREA;
         SU_AREA:  state_in = SU_RECIP;
         SU_RECIP: if (cnt_ff == '0) state_in = SU_IDLE;
         SU_IDLE:  state_in = SU_IDLE;
         default:  state_in = SU_LOAD;
      endcase
      if (write_hit) state_in = SU_LOAD;
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         SU_LOAD: begin
            sw_ff    <= sw_eff;
            sh_ff    <= sh_eff;
            tw_ff    <= tw_eff;
            th_ff    <= th_eff;
            acc_w_ff <= tw_eff;
            acc_h_ff <= th_eff;
            k_w_ff   <= SC_W'(1);
            k_h_ff   <= SC_W'(1);
         end
         SU_SCALE: begin
            if (adv_w) begin
               acc_w_ff <= acc_w_next[SIZE_W-1:0];
               k_w_ff   <= k_w_ff + SC_W'(1);
            end
            if (adv_h) begin
               acc_h_ff <= acc_h_next[SIZE_W-1:0];
               k_h_ff   <= k_h_ff + SC_W'(1);
            end
         end
         SU_AREA: begin
            area_ff <= AREA_W'((2 * SC_W)'(k_w_ff) * (2 * SC_W)'(k_h_ff));
            rem_ff  <= '0;
            q_ff    <= '0;
            cnt_ff  <= CNT_TOP;
         end
         SU_RECIP: begin
            rem_ff <= rem_in;
            q_ff   <= {q_ff[RCP_W-2:0], trial_ge};
            cnt_ff <= cnt_ff - CNT_W'(1);
         end
         default: ;
      endcase
   end

   assign ctl.busy      = (state_ff != SU_IDLE);
   assign ctl.restart   = write_hit;
   assign src_w         = sw_ff;
   assign src_h         = sh_ff;
   assign cover_w       = acc_w_ff;
   assign cover_h       = acc_h_ff;
   assign scale_w       = k_w_ff;
   assign scale_h       = k_h_ff;
   assign area          = area_ff;
   assign recip         = q_ff;
   assign four_channels = four_ff;

   `BFD_ASSERT(a_recip_ready, !ctl.busy |-> (area_ff != '0) && (q_ff != '0), "setup idle with zero area or reciprocal")

endmodule

`default_nettype wire

// File: hdl/bfd_accum.sv
// ----------------------------------------------------------------------------
// bfd_accum
// Raster position tracking and column sum store with read-modify-write.
// ----------------------------------------------------------------------------
`default_nettype none
`include "box_filter_downscaler_assert.svh"

module bfd_accum #(
   parameter int MAX_TARGET_WIDTH = 2048,
   parameter int MAX_SCALE        = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire bfd_pkg::ctl_type               ctl,
   input  wire logic                           accept,
   input  wire bfd_pkg::req_type               pixel,
   input  wire logic [bfd_pkg::SIZE_W-1:0]     src_w,
   input  wire logic [bfd_pkg::SIZE_W-1:0]     src_h,
   input  wire logic [bfd_pkg::SIZE_W-1:0]     cover_w,
   input  wire logic [bfd_pkg::SIZE_W-1:0]     cover_h,
   input  wire logic [$clog2(MAX_SCALE+1)-1:0] scale_w,
   input  wire logic [$clog2(MAX_SCALE+1)-1:0] scale_h,
   input  wire logic                           four_channels,
   output      logic                           emit_now,
   output      logic                           sum_valid,
   output      logic [bfd_pkg::CHAN_N-1:0]
                     [$clog2(((1 << bfd_pkg::PIX_W) - 1) * MAX_SCALE * MAX_SCALE + 1)-1:0]
                                               sums,
   output      logic                           sum_done
);
   import bfd_pkg::*;

   localparam int SC_W  = $clog2(MAX_SCALE + 1);
   localparam int FX_W  = $clog2(MAX_SCALE);
   localparam int OX_W  = $clog2(MAX_TARGET_WIDTH);
   localparam int SUM_W = $clog2(((1 << PIX_W) - 1) * MAX_SCALE * MAX_SCALE + 1);

   typedef logic [CHAN_N-1:0][SUM_W-1:0] sum_vec_type;
   typedef logic [CHAN_N-1:0][PIX_W-1:0] pix_vec_type;

   sum_vec_type sums_mem [MAX_TARGET_WIDTH];

   logic [POS_W-1:0] col_ff, row_ff;
   logic [FX_W-1:0]  fx_ff, fy_ff;
   logic [OX_W-1:0]  ox_ff;
   logic             col_end, row_end, last_x, last_y, first, covered, done;

   logic        s1_valid_ff, s1_first_ff, s1_last_ff, s1_done_ff, s1_fwd_ff;
   logic [OX_W-1:0] s1_addr_ff;
   pix_vec_type s1_pix_ff, pix_in;
   sum_vec_type rdata_ff, wsum_ff, new_sum;
   logic        sum_valid_ff, sum_done_ff;

   assign col_end = ({1'b0, col_ff} == src_w - SIZE_W'(1));
   assign row_end = ({1'b0, row_ff} == src_h - SIZE_W'(1));
   assign last_x  = (SC_W'(fx_ff) == scale_w - SC_W'(1));
   assign last_y  = (SC_W'(fy_ff) == scale_h - SC_W'(1));
   assign first   = (fx_ff == '0) && (fy_ff == '0);
   assign covered = ({1'b0, col_ff} < cover_w) && ({1'b0, row_ff} < cover_h);
   assign done    = ({1'b0, col_ff} == cover_w - SIZE_W'(1))
                 && ({1'b0, row_ff} == cover_h - SIZE_W'(1));
   assign emit_now = covered && last_x && last_y;

   assign pix_in[0] = pixel.in_chan0;
   assign pix_in[1] = pixel.in_chan1;
   assign pix_in[2] = pixel.in_chan2;
   assign pix_in[3] = four_channels ? pixel.in_chan3 : '0;

   always_ff @(posedge clock) begin
      if (reset || ctl.restart) begin
         col_ff <= '0;
         row_ff <= '0;
         fx_ff  <= '0;
         fy_ff  <= '0;
         ox_ff  <= '0;
      end else if (accept) begin
         if (col_end) begin
            col_ff <= '0;
            fx_ff  <= '0;
            ox_ff  <= '0;
            if (row_end) begin
               row_ff <= '0;
               fy_ff  <= '0;
            end else begin
               row_ff <= row_ff + POS_W'(1);
               fy_ff  <= last_y ? '0 : fy_ff + FX_W'(1);
            end
         end else begin
            col_ff <= col_ff + POS_W'(1);
            fx_ff  <= last_x ? '0 : fx_ff + FX_W'(1);
            ox_ff  <= ox_ff + OX_W'(last_x);
         end
      end
   end

   // stage 1: store read in flight; forward when the item ahead writes this entry
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= accept && covered;
         sum_valid_ff <= s1_valid_ff && s1_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && covered) begin
         rdata_ff    <= sums_mem[ox_ff];
         s1_addr_ff  <= ox_ff;
         s1_pix_ff   <= pix_in;
         s1_first_ff <= first;
         s1_last_ff  <= last_x && last_y;
         s1_done_ff  <= done;
         s1_fwd_ff   <= s1_valid_ff && (s1_addr_ff == ox_ff);
      end
      if (s1_valid_ff) begin
         sums_mem[s1_addr_ff] <= new_sum;
         wsum_ff              <= new_sum;
         sum_done_ff          <= s1_done_ff;
      end
   end

   always_comb begin
      for (int c = 0; c < CHAN_N; c++) begin
         if (s1_first_ff)    new_sum[c] = SUM_W'(s1_pix_ff[c]);
         else if (s1_fwd_ff) new_sum[c] = wsum_ff[c] + SUM_W'(s1_pix_ff[c]);
         else                new_sum[c] = rdata_ff[c] + SUM_W'(s1_pix_ff[c]);
      end
   end

   assign sum_valid = sum_valid_ff;
   assign sums      = wsum_ff;
   assign sum_done  = sum_done_ff;

   `BFD_ASSERT(a_fwd_after_write, s1_valid_ff && s1_fwd_ff |-> $past(s1_valid_ff), "forward without a write ahead")

endmodule

`default_nettype wire

// File: hdl/bfd_mean.sv
// ----------------------------------------------------------------------------
// bfd_mean
// Four-lane box mean: reciprocal multiply with one-step correction.
// ----------------------------------------------------------------------------
`default_nettype none

module bfd_mean #(
   parameter int MAX_SCALE = 16
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           in_valid,
   input  wire logic [bfd_pkg::CHAN_N-1:0]
                     [$clog2(((1 << bfd_pkg::PIX_W) - 1) * MAX_SCALE * MAX_SCALE + 1)-1:0]
                                               in_sums,
   input  wire logic                           in_done,
   input  wire logic [$clog2(MAX_SCALE*MAX_SCALE+1)-1:0] area,
   input  wire logic [$clog2(((1 << bfd_pkg::PIX_W) - 1) * MAX_SCALE * MAX_SCALE + 1):0]
                                               recip,
   output      logic                           out_valid,
   output      bfd_pkg::rsp_type               out_pixel
);
   import bfd_pkg::*;

   localparam int AREA_W = $clog2(MAX_SCALE * MAX_SCALE + 1);
   localparam int SUM_W  = $clog2(((1 << PIX_W) - 1) * MAX_SCALE * MAX_SCALE + 1);
   localparam int RCP_W  = SUM_W + 1;
   localparam int PRD_W  = SUM_W + RCP_W;
   localparam int QA_W   = PIX_W + AREA_W;

   typedef logic [CHAN_N-1:0][SUM_W-1:0] sum_vec_type;

   logic                         p1_valid_ff, p2_valid_ff, out_valid_ff;
   logic                         p1_done_ff, p2_done_ff;
   logic [CHAN_N-1:0][PRD_W-1:0] p1_prod_ff;
   sum_vec_type                  p1_sum_ff, p2_sum_ff, p2_qa_ff, rem;
   logic [CHAN_N-1:0][PIX_W-1:0] p2_q_ff, q_fix;
   rsp_type                      out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= in_valid;
         p2_valid_ff  <= p1_valid_ff;
         out_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < CHAN_N; c++) begin
         p1_prod_ff[c] <= PRD_W'(in_sums[c]) * PRD_W'(recip);
         p2_q_ff[c]    <= p1_prod_ff[c][SUM_W +: PIX_W];
         p2_qa_ff[c]   <= SUM_W'(QA_W'(p1_prod_ff[c][SUM_W +: PIX_W]) * QA_W'(area));
      end
      p1_sum_ff  <= in_sums;
      p1_done_ff <= in_done;
      p2_sum_ff  <= p1_sum_ff;
      p2_done_ff <= p1_done_ff;
      out_ff     <= {q_fix[0], q_fix[1], q_fix[2], q_fix[3], p2_done_ff};
   end

   // estimate is low by at most one
   always_comb begin
      for (int c = 0; c < CHAN_N; c++) begin
         rem[c]   = p2_sum_ff[c] - p2_qa_ff[c];
         q_fix[c] = p2_q_ff[c] + PIX_W'(rem[c] >= SUM_W'(area));
      end
   end

   assign out_valid = out_valid_ff;
   assign out_pixel = out_ff;

endmodule

`default_nettype wire

// File: hdl/bfd_outq.sv
// ----------------------------------------------------------------------------
// bfd_outq
// Result queue between the mean pipeline and the response channel.
// ----------------------------------------------------------------------------
`default_nettype none
`include "box_filter_downscaler_assert.svh"

module bfd_outq (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire bfd_pkg::rsp_type push_data,
   input  wire logic             pop,
   output      logic             head_valid,
   output      bfd_pkg::rsp_type head_data
);
   import bfd_pkg::*;

   rsp_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0] count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop)        rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_ff + QCNT_W'(push_valid) - QCNT_W'(pop);
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) slot_ff[wr_ptr_ff] <= push_data;
   end

   assign head_valid = (count_ff != '0);
   assign head_data  = slot_ff[rd_ptr_ff];

   `BFD_ASSERT_NEVER(a_no_overflow, push_valid && !pop && (count_ff == QCNT_W'(QUEUE_DEPTH)), "result queue overflow")
   `BFD_ASSERT_NEVER(a_no_underflow, pop && (count_ff == '0), "result queue underflow")

endmodule

`default_nettype wire

// File: hdl/box_filter_downscaler.sv
// A result passes the sum store read stage, the sum register, mean stages p1, p2 and out,
// and the result queue. Throughput: one pixel beat per cycle while req_stall is low;
// the column sum store has one read and one write port. A queue of 8 results with credit
// counting stalls input when results back up. Reset is synchronous; registers come up as 1
// and the setup unit then loads sizes, searches scales and computes box area and reciprocal,
// holding req_stall high. Defined config register writes repeat setup and restart the frame.
// ----------------------------------------------------------------------------
// box_filter_downscaler
// Integer box filter image downscaler, one source pixel per beat in raster order.
// ----------------------------------------------------------------------------
`default_nettype none
`include "box_filter_downscaler_assert.svh"

module box_filter_downscaler #(
   parameter int MAX_TARGET_WIDTH = 2048,
   parameter int MAX_SCALE        = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire bfd_pkg::req_type                req_payload,
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      bfd_pkg::rsp_type                rsp_payload,
   input  wire logic                            csr_valid,
   output      logic                            csr_ready,
   input  wire logic [bfd_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [bfd_pkg::CSR_DATA_W-1:0]  csr_data
);
   import bfd_pkg::*;

   localparam int SC_W   = $clog2(MAX_SCALE + 1);
   localparam int AREA_W = $clog2(MAX_SCALE * MAX_SCALE + 1);
   localparam int SUM_W  = $clog2(((1 << PIX_W) - 1) * MAX_SCALE * MAX_SCALE + 1);
   localparam int RCP_W  = SUM_W + 1;

   ctl_type           ctl;
   logic [SIZE_W-1:0] src_w, src_h, cover_w, cover_h;
   logic [SC_W-1:0]   scale_w, scale_h;
   logic [AREA_W-1:0] area;
   logic [RCP_W-1:0]  recip;
   logic              four_channels;
   logic              accept, emit_now, pop;
   logic              sum_valid, sum_done, mean_valid;
   logic [CHAN_N-1:0][SUM_W-1:0] sums;
   rsp_type           mean_pixel;
   logic [QCNT_W-1:0] credit_ff, credit_in;

   bfd_setup #(
      .MAX_TARGET_WIDTH (MAX_TARGET_WIDTH),
      .MAX_SCALE        (MAX_SCALE)
   ) u_setup (
      .clock         (clock),
      .reset         (reset),
      .csr_valid     (csr_valid),
      .csr_ready     (csr_ready),
      .csr_index     (csr_index),
      .csr_data      (csr_data),
      .ctl           (ctl),
      .src_w         (src_w),
      .src_h         (src_h),
      .cover_w       (cover_w),
      .cover_h       (cover_h),
      .scale_w       (scale_w),
      .scale_h       (scale_h),
      .area          (area),
      .recip         (recip),
      .four_channels (four_channels)
   );

   bfd_accum #(
      .MAX_TARGET_WIDTH (MAX_TARGET_WIDTH),
      .MAX_SCALE        (MAX_SCALE)
   ) u_accum (
      .clock         (clock),
      .reset         (reset),
      .ctl           (ctl),
      .accept        (accept),
      .pixel         (req_payload),
      .src_w         (src_w),
      .src_h         (src_h),
      .cover_w       (cover_w),
      .cover_h       (cover_h),
      .scale_w       (scale_w),
      .scale_h       (scale_h),
      .four_channels (four_channels),
      .emit_now      (emit_now),
      .sum_valid     (sum_valid),
      .sums          (sums),
      .sum_done      (sum_done)
   );

   bfd_mean #(
      .MAX_SCALE (MAX_SCALE)
   ) u_mean (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_sums   (sums),
      .in_done   (sum_done),
      .area      (area),
      .recip     (recip),
      .out_valid (mean_valid),
      .out_pixel (mean_pixel)
   );

   bfd_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push_valid (mean_valid),
      .push_data  (mean_pixel),
      .pop        (pop),
      .head_valid (rsp_valid),
      .head_data  (rsp_payload)
   );

   // credits cover results in flight plus results queued
   assign req_stall = ctl.busy || (credit_ff == QCNT_W'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;
   assign pop       = rsp_valid && !rsp_stall;
   assign credit_in = credit_ff + QCNT_W'(accept && emit_now) - QCNT_W'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         credit_ff <= '0;
      end else begin
         credit_ff <= credit_in;
      end
   end

   `BFD_ASSERT(a_credit_bound, credit_ff <= QCNT_W'(QUEUE_DEPTH), "credit count above queue depth")
   `BFD_ASSERT(a_rsp_has_credit, rsp_valid |-> (credit_ff != '0), "result beat without credit")

endmodule

`default_nettype wire

// File: dv/box_filter_downscaler_tb.sv
// ----------------------------------------------------------------------------
// box_filter_downscaler_tb
// Streams source pixels through the downscaler under random input gaps and
// output stalls. A scoreboard keeps its own column sums and raster position,
// predicts every box mean and checks each result beat in order. Frame sizes,
// channel mode and register clamping change between phases.
// ----------------------------------------------------------------------------
`default_nettype none

module box_filter_downscaler_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bfd_pkg::*;

   localparam int unsigned MAX_TW       = 2048;
   localparam int unsigned MAX_SC       = 16;
   localparam int          RANDOM_ITEMS = 800;
   localparam int          DRAIN_SLACK  = 16;
   localparam int          CYCLE_LIMIT  = 2000000;

   class box_scoreboard;
      logic [SIZE_W-1:0]      src_w_reg, src_h_reg, tgt_h_reg;
      logic [TGT_W_REG_W-1:0] tgt_w_reg;
      bit                     four_reg;
      bit [31:0]              col_sum [MAX_TW][CHAN_N];
      int unsigned            col_pos, row_pos;
      rsp_type                box_means[$];
      int                     errors;
      int                     results_seen;

      function new();
         src_w_reg = 1;
         src_h_reg = 1;
         tgt_w_reg = 1;
         tgt_h_reg = 1;
         four_reg  = 1'b1;
         col_pos   = 0;
         row_pos   = 0;
         errors    = 0;
         results_seen = 0;
      endfunction

      static function int unsigned clamp(int unsigned v, int unsigned lo, int unsigned hi);
         if (v < lo) return lo;
         if (v > hi) return hi;
         return v;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            REG_SOURCE_WIDTH:  src_w_reg = data;
            REG_SOURCE_HEIGHT: src_h_reg = data;
            REG_TARGET_WIDTH:  tgt_w_reg = data[TGT_W_REG_W-1:0];
            REG_TARGET_HEIGHT: tgt_h_reg = data;
            REG_FOUR_CHANNELS: four_reg  = data[0];
            default:           return;
         endcase
         col_pos = 0;
         row_pos = 0;
      endfunction

      function void note_pixel(req_type px);
         int unsigned    sw, sh, tw, th, scw, sch, c, r, ox, oy, fx, fy, area;
         bit [PIX_W-1:0] chan [CHAN_N];
         rsp_type        mean;
         sw = clamp(src_w_reg, 1, SOURCE_LIMIT);
         sh = clamp(src_h_reg, 1, SOURCE_LIMIT);
         tw = clamp(tgt_w_reg, 1, sw);
         th = clamp(tgt_h_reg, 1, sh);
         if (tw > MAX_TW) tw = MAX_TW;
         scw = clamp(sw / tw, 1, MAX_SC);
         sch = clamp(sh / th, 1, MAX_SC);
         c = col_pos;
         r = row_pos;
         if (c >= sw) c = 0;
         if (r >= sh) r = 0;
         chan = '{px.in_chan0, px.in_chan1, px.in_chan2, px.in_chan3};
         if (c < tw * scw && r < th * sch) begin
            ox = c / scw;
            fx = c % scw;
            oy = r / sch;
            fy = r % sch;
            for (int k = 0; k < CHAN_N; k++) begin
               if (k == CHAN_N - 1 && !four_reg) col_sum[ox][k] = 0;
               else if (fx == 0 && fy == 0)      col_sum[ox][k] = chan[k];
               else                              col_sum[ox][k] += chan[k];
            end
            if (fx == scw - 1 && fy == sch - 1) begin
               area = scw * sch;
               mean.out_chan0  = PIX_W'(col_sum[ox][0] / area);
               mean.out_chan1  = PIX_W'(col_sum[ox][1] / area);
               mean.out_chan2  = PIX_W'(col_sum[ox][2] / area);
               mean.out_chan3  = PIX_W'(col_sum[ox][3] / area);
               mean.image_done = (ox == tw - 1 && oy == th - 1);
               box_means.push_back(mean);
            end
         end
         c++;
         if (c >= sw) begin
            c = 0;
            r++;
            if (r >= sh) r = 0;
         end
         col_pos = c;
         row_pos = r;
      endfunction

      function void check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (box_means.size() == 0) begin
            errors++;
            if (errors <= 10)
               $display("%0t unexpected result beat: %02h %02h %02h %02h done=%0b", $realtime,
                        got.out_chan0, got.out_chan1, got.out_chan2, got.out_chan3,
                        got.image_done);
            return;
         end
         want = box_means.pop_front();
         if (got.out_chan0 !== want.out_chan0 || got.out_chan1 !== want.out_chan1 ||
             got.out_chan2 !== want.out_chan2 || got.out_chan3 !== want.out_chan3 ||
             got.image_done !== want.image_done) begin
            errors++;
            if (errors <= 10)
               $display("%0t mismatch: exp %02h %02h %02h %02h done=%0b, got %02h %02h %02h %02h done=%0b",
                        $realtime, want.out_chan0, want.out_chan1, want.out_chan2,
                        want.out_chan3, want.image_done, got.out_chan0, got.out_chan1,
                        got.out_chan2, got.out_chan3, got.image_done);
         end
      endfunction

      function int outstanding();
         return box_means.size();
      endfunction
   endclass

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   box_scoreboard sb;
   bit            quiet_req = 1'b0;
   int            random_items = 0;
   int            cycles = 0;
   int            stall_hold = 0;
   int            stall_pick;

   box_filter_downscaler DUT (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("box_filter_downscaler_tb: FAIL");
         $finish;
      end
   end

   // beat monitor
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_stall === 1'b0) sb.note_pixel(req_payload);
         if (rsp_valid === 1'b1 && !rsp_stall) sb.check_result(rsp_payload);
         if (csr_valid && csr_ready === 1'b1) sb.write_reg(csr_index, csr_data);
      end
   end

   // output back-pressure: short and long stalls, with long free stretches
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_hold <= 0;
      end else if (stall_hold > 0) begin
         stall_hold <= stall_hold - 1;
      end else begin
         stall_pick = $urandom_range(0, 99);
         if (stall_pick < 35) begin
            rsp_stall  <= 1'b1;
            stall_hold <= (stall_pick < 32) ? $urandom_range(0, 3) : $urandom_range(15, 60);
         end else begin
            rsp_stall  <= 1'b0;
            stall_hold <= (stall_pick < 90) ? $urandom_range(0, 8) : $urandom_range(50, 300);
         end
      end
   end

   function automatic int pick_gap();
      int r;
      if (quiet_req) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [PIX_W-1:0] pick_byte();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return '0;
      if (r == 1) return '1;
      return PIX_W'($urandom_range(0, 255));
   endfunction

   function automatic req_type rand_pixel();
      req_type px;
      px.in_chan0 = pick_byte();
      px.in_chan1 = pick_byte();
      px.in_chan2 = pick_byte();
      px.in_chan3 = pick_byte();
      return px;
   endfunction

   function automatic int unsigned pick_extreme();
      case ($urandom_range(0, 3))
         0:       return 0;
         1:       return SOURCE_LIMIT;
         2:       return (1 << SIZE_W) - 1;
         default: return $urandom_range(0, (1 << SIZE_W) - 1);
      endcase
   endfunction

   task automatic send_pixel(req_type px);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= px;
      do @(posedge clock); while (req_stall !== 1'b0);
   endtask

   task automatic send_random(int n);
      repeat (n) send_pixel(rand_pixel());
      req_valid <= 1'b0;
   endtask

   task automatic csr_write(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         csr_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      do @(posedge clock); while (csr_ready !== 1'b1);
   endtask

   task automatic configure(int unsigned sw, int unsigned sh, int unsigned tw,
                            int unsigned th, bit four);
      csr_write(REG_SOURCE_WIDTH,  CSR_DATA_W'(sw));
      csr_write(REG_SOURCE_HEIGHT, CSR_DATA_W'(sh));
      csr_write(REG_TARGET_WIDTH,  CSR_DATA_W'(tw));
      csr_write(REG_TARGET_HEIGHT, CSR_DATA_W'(th));
      csr_write(REG_FOUR_CHANNELS, CSR_DATA_W'(four));
      csr_valid <= 1'b0;
   endtask

   task automatic poke_unused();
      csr_write(CSR_INDEX_W'($urandom_range(REG_FOUR_CHANNELS + 1, (1 << CSR_INDEX_W) - 1)),
                CSR_DATA_W'($urandom_range(0, (1 << CSR_DATA_W) - 1)));
      csr_valid <= 1'b0;
   endtask

   // wait for every predicted beat, then let discarded pixels flush out
   task automatic settle();
      while (sb.outstanding() > 0) @(posedge clock);
      repeat (DRAIN_SLACK) @(posedge clock);
   endtask

   task automatic run_random_phase();
      int unsigned sw, sh, tw, th, kind, n, frame;
      bit          four;
      kind      = $urandom_range(0, 99);
      quiet_req = ($urandom_range(0, 4) == 0);
      four      = $urandom_range(0, 1);
      if (kind < 60) begin
         sw = $urandom_range(1, 24);
         sh = $urandom_range(1, 24);
         tw = ($urandom_range(0, 6) != 0) ? $urandom_range(1, sw) : $urandom_range(0, 30);
         th = ($urandom_range(0, 6) != 0) ? $urandom_range(1, sh) : $urandom_range(0, 30);
         if ($urandom_range(0, 9) == 0) tw = tw | ($urandom_range(1, 3) << TGT_W_REG_W);
         configure(sw, sh, tw, th, four);
         frame = sw * sh;
         n = frame * $urandom_range(1, 2);
         if ($urandom_range(0, 2) == 0) n += $urandom_range(0, frame);
         if (n > 300) n = 300;
      end else if (kind < 70) begin
         if ($urandom_range(0, 1)) begin
            tw = $urandom_range(1, 2);
            sw = $urandom_range(MAX_SC * tw + 1, MAX_SC * tw + 24);
            sh = $urandom_range(1, 3);
            th = sh;
         end else begin
            sw = $urandom_range(1, 3);
            tw = sw;
            th = $urandom_range(1, 2);
            sh = $urandom_range(MAX_SC * th + 1, MAX_SC * th + 8);
         end
         configure(sw, sh, tw, th, four);
         n = sw * sh + $urandom_range(0, sw * sh / 2);
         if (n > 400) n = 400;
      end else if (kind < 80) begin
         sw = pick_extreme();
         sh = pick_extreme();
         case ($urandom_range(0, 3))
            0:       tw = 0;
            1:       tw = (1 << TGT_W_REG_W) - 1;
            2:       tw = MAX_TW;
            default: tw = $urandom_range(0, (1 << TGT_W_REG_W) - 1);
         endcase
         th = pick_extreme();
         configure(sw, sh, tw, th, four);
         n = 150;
      end else if (kind < 90) begin
         // frame keeps going: unused indexes must not restart it
         if ($urandom_range(0, 1)) poke_unused();
         n = 100;
      end else begin
         csr_write(REG_FOUR_CHANNELS, CSR_DATA_W'(four));
         csr_valid <= 1'b0;
         n = 100;
      end
      send_random(n);
      random_items += n;
      settle();
   endtask

   initial begin
      req_type px;
      sb = new();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // registers at reset: one pixel in, same pixel out
      send_pixel('0);
      send_pixel('1);
      req_valid <= 1'b0;
      settle();

      // zero sizes clamp to one, three-channel mode
      configure(0, 0, 0, 0, 0);
      poke_unused();
      send_pixel('1);
      send_pixel('0);
      req_valid <= 1'b0;
      settle();

      // 2x1 boxes, last source column discarded, target width top bits masked
      configure(5, 1, 2 | (1 << TGT_W_REG_W), 1, 1);
      send_pixel('1);
      send_pixel('{8'hFF, 8'h00, 8'h80, 8'h01});
      send_pixel('0);
      send_pixel('{8'h01, 8'hFF, 8'h03, 8'hFE});
      send_pixel('1);
      req_valid <= 1'b0;
      settle();

      // vertical scale clamped to the maximum, bottom row discarded
      configure(1, MAX_SC + 1, 1, 1, 0);
      for (int i = 0; i <= MAX_SC; i++) begin
         px = (i < MAX_SC - 1) ? '1 : '0;
         send_pixel(px);
      end
      req_valid <= 1'b0;
      settle();

      // wide row, target width clamped to the source width
      configure(MAX_TW / 4, 1, (1 << TGT_W_REG_W) - 1, 1, 1);
      send_random(MAX_TW / 4);
      settle();

      while (random_items < RANDOM_ITEMS)
         run_random_phase();

      if (sb.errors == 0 && sb.outstanding() == 0) begin
         $display("box_filter_downscaler_tb: PASS");
      end else begin
         $display("box_filter_downscaler_tb: FAIL");
      end
      $finish;
   end

endmodule

`default_nettype wire
